// ----- src/lwt_pkg.sv -----
// Shared types, constants and arithmetic helpers for the 2D 5/3 lifting wavelet block.
// No dependencies; used by every module of the block.
`default_nettype none
package lwt_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int MAX_LEVELS  = 8;
    localparam int SAMPLE_BITS = 32;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int FRAME_AW = ROW_W + COL_W;
    localparam int LINE_LEN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int LINE_AW  = $clog2(LINE_LEN);
    localparam int DIM_W    = 10;
    localparam int LVL_W    = 4;

    localparam logic [30:0] ROOT2_Q30    = 31'd1518500250;
    localparam logic [30:0] INVROOT2_Q30 = 31'd759250125;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_LEVELS = 2'd3;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_RUN  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        E_IDLE,
        E_LOAD,
        E_LIFT1,
        E_LIFT2,
        E_STORE
    } t_eng_state;

    typedef enum logic [1:0] {
        SC_NONE,
        SC_ROOT,
        SC_INV
    } t_scale_sel;

    typedef struct packed {
        logic             start;
        logic             inv;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [LVL_W-1:0] lv;
    } t_run_cmd;

    typedef struct packed {
        logic                          we;
        logic [FRAME_AW-1:0]           addr;
        logic signed [SAMPLE_BITS-1:0] wdata;
    } t_fmem_req;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_wide(
        input logic signed [SAMPLE_BITS+1:0] v
    );
        logic signed [SAMPLE_BITS+1:0] hi;
        logic signed [SAMPLE_BITS+1:0] lo;
        hi = (SAMPLE_BITS+2)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        lo = -hi - (SAMPLE_BITS+2)'(1);
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/lifting_wavelet_2d_multilevel.sv -----
// Top level of the multi-level 2D 5/3 lifting wavelet: request decode, configuration,
// frame memory and result register. Depends on lwt_pkg and lwt_engine.
//
// Usage: drive a request (type, row, col, sample) with start high while busy is low.
// Each request gives exactly one result on o_value/o_status, marked by o_done for one
// cycle; the receiver cannot hold it off.
//  - load: written into the frame memory; result in the cycle after the request.
//  - read: frame memory read (registered), then the result register; busy is high for one
//    cycle, so a new read is not taken until the previous one's result is registered.
//  - run: the engine transforms the frame in place, level by level, one line at a time
//    through the line memory. Per line: load the samples, run the two lifting steps over
//    the sample pairs, then store them back. An invalid size answers status 1 next cycle.
//  - out-of-range load or read answers status 2 next cycle; type 3 answers status 0.
// Configuration writes (mode, width, height, levels) take effect at once; the user must
// make them only while idle (not enforced). Reset clears control state and sets config
// to its defaults; memory stays undefined until written, and no clearing pass runs.
`default_nettype none
module lifting_wavelet_2d_multilevel (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [1:0]                             i_req_type,
    input  wire logic [8:0]                             i_row,
    input  wire logic [8:0]                             i_col,
    input  wire logic signed [31:0]                     i_sample,
    input  wire logic                                   i_cfg_we,
    input  wire logic [1:0]                             i_cfg_idx,
    input  wire logic [9:0]                             i_cfg_data,
    output logic                                        o_done,
    output logic signed [31:0]                          o_value,
    output logic [1:0]                                  o_status
);
    localparam int DW = lwt_pkg::DIM_W;
    localparam int LV = lwt_pkg::LVL_W;
    localparam int FA = lwt_pkg::FRAME_AW;

    logic          r_mode;
    logic [DW-1:0] r_w, r_h;
    logic [LV-1:0] r_lv;
    logic          r_done, n_done, r_pend, n_pend, r_run, n_run;
    logic signed [31:0] r_value, n_value;
    logic [1:0]    r_status, n_status;

    logic signed [31:0] frame_mem [1 << FA];
    logic signed [31:0] r_fq;

    logic               w_accept, w_inside, w_size_ok;
    logic [DW-1:0]      w_mask;
    lwt_pkg::t_req      w_req;
    lwt_pkg::t_run_cmd  w_cmd;
    lwt_pkg::t_fmem_req w_eng_mem;
    logic               w_eng_done;
    logic               w_we;
    logic [FA-1:0]      w_addr;
    logic signed [31:0] w_wdata;

    lwt_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_frame_rdata (r_fq),
        .o_fmem        (w_eng_mem),
        .o_done        (w_eng_done)
    );

    always_comb begin
        busy      = r_pend | r_run;
        w_accept  = start && !busy;
        w_req     = lwt_pkg::t_req'(i_req_type);
        w_inside  = (DW'(i_row) < r_h) && (DW'(i_col) < r_w);
        w_mask    = (DW'(1) << r_lv) - DW'(1);
        w_size_ok = (r_lv >= LV'(1)) && (r_lv <= LV'(lwt_pkg::MAX_LEVELS))
                 && (r_w <= DW'(lwt_pkg::MAX_WIDTH)) && (r_h <= DW'(lwt_pkg::MAX_HEIGHT))
                 && ((r_w & w_mask) == '0) && ((r_h & w_mask) == '0)
                 && ((r_w >> r_lv) >= DW'(2)) && ((r_h >> r_lv) >= DW'(2));

        w_cmd.start = 1'b0;
        w_cmd.inv   = r_mode;
        w_cmd.w     = r_w;
        w_cmd.h     = r_h;
        w_cmd.lv    = r_lv;

        n_done   = 1'b0;
        n_pend   = r_pend;
        n_run    = r_run;
        n_value  = '0;
        n_status = lwt_pkg::ST_OK;

        if (r_pend) begin
            n_done  = 1'b1;
            n_pend  = 1'b0;
            n_value = r_fq;
        end else if (r_run) begin
            if (w_eng_done) begin
                n_done = 1'b1;
                n_run  = 1'b0;
            end
        end else if (w_accept) begin
            unique case (w_req)
                lwt_pkg::REQ_LOAD: begin
                    n_done   = 1'b1;
                    n_status = w_inside ? lwt_pkg::ST_OK : lwt_pkg::ST_BAD_INDEX;
                end
                lwt_pkg::REQ_READ: begin
                    n_pend   = w_inside;
                    n_done   = !w_inside;
                    n_status = w_inside ? lwt_pkg::ST_OK : lwt_pkg::ST_BAD_INDEX;
                end
                lwt_pkg::REQ_RUN: begin
                    n_run       = w_size_ok;
                    n_done      = !w_size_ok;
                    n_status    = w_size_ok ? lwt_pkg::ST_OK : lwt_pkg::ST_BAD_SIZE;
                    w_cmd.start = w_size_ok;
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end

        if (r_run) begin
            w_we    = w_eng_mem.we;
            w_addr  = w_eng_mem.addr;
            w_wdata = w_eng_mem.wdata;
        end else begin
            w_we    = w_accept && (w_req == lwt_pkg::REQ_LOAD) && w_inside;
            w_addr  = {i_row, i_col};
            w_wdata = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            frame_mem[w_addr] <= w_wdata;
        end
        r_fq     <= frame_mem[w_addr];
        r_value  <= n_value;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_w    <= DW'(lwt_pkg::MAX_WIDTH);
            r_h    <= DW'(lwt_pkg::MAX_HEIGHT);
            r_lv   <= LV'(1);
            r_done <= 1'b0;
            r_pend <= 1'b0;
            r_run  <= 1'b0;
        end else begin
            r_done <= n_done;
            r_pend <= n_pend;
            r_run  <= n_run;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lwt_pkg::CFG_MODE:   r_mode <= i_cfg_data[0];
                    lwt_pkg::CFG_WIDTH:  r_w    <= i_cfg_data;
                    lwt_pkg::CFG_HEIGHT: r_h    <= i_cfg_data;
                    lwt_pkg::CFG_LEVELS: r_lv   <= i_cfg_data[LV-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_status = r_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == lwt_pkg::REQ_LOAD) |=> o_done)
        else $error("load result missing");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == lwt_pkg::REQ_READ && w_inside) |=> ##1 o_done)
        else $error("read result missing");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != lwt_pkg::ST_OK) |-> o_value == '0)
        else $error("failed request carries a value");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && w_eng_mem.we) |-> !r_pend)
        else $error("engine write overlaps a pending read");
endmodule
`default_nettype wire

// ----- src/lwt_scale.sv -----
// Q30 sqrt2 / 1/sqrt2 scale or pass-through: one registered multiply, round, negate, saturate.
// Depends on lwt_pkg.
`default_nettype none
module lwt_scale (
    input  wire logic                                  i_clk,
    input  wire logic signed [lwt_pkg::SAMPLE_BITS-1:0] i_data,
    input  wire lwt_pkg::t_scale_sel                   i_sel,
    output logic signed [lwt_pkg::SAMPLE_BITS-1:0]      o_data
);
    localparam int SB = lwt_pkg::SAMPLE_BITS;
    localparam int PW = SB + 31;

    logic [SB-1:0]         w_mag;
    logic [30:0]           w_coef;
    logic [PW-1:0]         r_prod;
    logic                  r_neg;
    lwt_pkg::t_scale_sel   r_sel;
    logic signed [SB-1:0]  r_raw;
    logic [PW-1:0]         w_rsum;
    logic [PW-31:0]        w_rnd;
    logic [PW-31:0]        w_max;

    always_comb begin
        w_mag  = i_data[SB-1] ? SB'(-i_data) : i_data;
        w_coef = (i_sel == lwt_pkg::SC_ROOT) ? lwt_pkg::ROOT2_Q30 : lwt_pkg::INVROOT2_Q30;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_mag) * PW'(w_coef);
        r_neg  <= i_data[SB-1];
        r_sel  <= i_sel;
        r_raw  <= i_data;
    end

    always_comb begin
        w_rsum = r_prod + (PW'(1) << 29);
        w_rnd  = w_rsum[PW-1:30];
        w_max  = (PW-30)'({1'b0, {(SB-1){1'b1}}});
        if (r_sel == lwt_pkg::SC_NONE) begin
            o_data = r_raw;
        end else if (!r_neg) begin
            o_data = (w_rnd > w_max) ? w_max[SB-1:0] : w_rnd[SB-1:0];
        end else if (w_rnd > w_max + (PW-30)'(1)) begin
            o_data = {1'b1, {(SB-1){1'b0}}};
        end else begin
            o_data = SB'(-w_rnd);
        end
    end
endmodule
`default_nettype wire

// ----- src/lwt_engine.sv -----
// Run sequencer: walks levels, passes and lines, holds the line memory and lifts each line.
// Depends on lwt_pkg and lwt_scale; drives the frame memory port of the top level.
`default_nettype none
module lwt_engine (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire lwt_pkg::t_run_cmd                     i_cmd,
    input  wire logic signed [lwt_pkg::SAMPLE_BITS-1:0] i_frame_rdata,
    output lwt_pkg::t_fmem_req                          o_fmem,
    output logic                                        o_done
);
    localparam int SB = lwt_pkg::SAMPLE_BITS;
    localparam int DW = lwt_pkg::DIM_W;
    localparam int LA = lwt_pkg::LINE_AW;
    localparam int FA = lwt_pkg::FRAME_AW;
    localparam int LV = lwt_pkg::LVL_W;

    lwt_pkg::t_eng_state r_state, n_state;
    logic          r_inv, n_inv;
    logic [LV-1:0] r_lv, n_lv, r_lvl, n_lvl;
    logic          r_pass, n_pass;
    logic [DW-1:0] r_w, n_w, r_h, n_h, r_line, n_line, r_k, n_k;
    logic [1:0]    r_m, n_m;
    logic          r_v1, r_v2;
    logic [FA-1:0] r_d1, r_d2;
    lwt_pkg::t_scale_sel r_sc1;
    logic signed [SB-1:0] r_a, n_a, r_b, n_b;

    logic signed [SB-1:0] line_mem [lwt_pkg::LINE_LEN];
    logic signed [SB-1:0] r_lq;

    logic          w_rows, w_pred, w_sub, w_issue;
    logic [DW-1:0] w_n, w_half, w_cnt, w_perm, w_ua, w_ub;
    logic [FA-1:0] w_faddr, w_dest;
    lwt_pkg::t_scale_sel w_sel;
    logic [LA-1:0] w_raddr, w_waddr;
    logic          w_lwe;
    logic signed [SB-1:0] w_lwdata, w_sc_in, w_sc_out;
    logic signed [SB:0]   w_sum;
    logic signed [SB+1:0] w_shift, w_res;

    lwt_scale u_scale (
        .i_clk  (i_clk),
        .i_data (w_sc_in),
        .i_sel  (r_sc1),
        .o_data (w_sc_out)
    );

    always_comb begin
        w_rows  = r_inv ? r_pass : !r_pass;
        w_n     = w_rows ? r_w : r_h;
        w_half  = w_n >> 1;
        w_cnt   = w_rows ? r_h : r_w;
        w_pred  = (r_state == lwt_pkg::E_LIFT1) ^ r_inv;
        w_sub   = r_inv ? !w_pred : w_pred;
        w_faddr = w_rows ? {r_line[LA-1:0], r_k[LA-1:0]} : {r_k[LA-1:0], r_line[LA-1:0]};
        w_perm  = r_k[0] ? w_half + (r_k >> 1) : (r_k >> 1);
        w_issue = ((r_state == lwt_pkg::E_LOAD) || (r_state == lwt_pkg::E_STORE)) && (r_k < w_n);
        w_sc_in = (r_state == lwt_pkg::E_LOAD) ? i_frame_rdata : r_lq;

        w_ua = w_pred ? DW'(0) : w_half;
        if (w_pred) begin
            w_ub = (r_k == w_half - DW'(1)) ? w_half - DW'(2) : r_k + DW'(1);
        end else begin
            w_ub = (r_k == DW'(0)) ? DW'(1) : r_k - DW'(1);
            w_ub = w_ub + w_half;
        end

        w_sum   = (SB+1)'(r_a) + (SB+1)'(r_b);
        w_shift = w_pred ? (SB+2)'(w_sum >>> 1) : (SB+2)'(w_sum >>> 2);
        w_res   = w_sub ? (SB+2)'(r_lq) - w_shift : (SB+2)'(r_lq) + w_shift;

        w_dest  = '0;
        w_sel   = lwt_pkg::SC_NONE;
        w_raddr = '0;
        w_waddr = r_d2[LA-1:0];
        w_lwe   = 1'b0;
        w_lwdata = w_sc_out;
        o_fmem.we    = 1'b0;
        o_fmem.addr  = w_faddr;
        o_fmem.wdata = w_sc_out;

        unique case (r_state)
            lwt_pkg::E_LOAD: begin
                w_dest = FA'(r_inv ? r_k : w_perm);
                if (r_inv) begin
                    w_sel = (r_k < w_half) ? lwt_pkg::SC_INV : lwt_pkg::SC_ROOT;
                end
                w_lwe = r_v2;
            end
            lwt_pkg::E_STORE: begin
                w_dest  = w_faddr;
                w_raddr = LA'(r_inv ? w_perm : r_k);
                if (!r_inv) begin
                    w_sel = (r_k < w_half) ? lwt_pkg::SC_ROOT : lwt_pkg::SC_INV;
                end
                o_fmem.we   = r_v2;
                o_fmem.addr = r_d2;
            end
            lwt_pkg::E_LIFT1, lwt_pkg::E_LIFT2: begin
                case (r_m)
                    2'd0:    w_raddr = LA'(w_ua + r_k);
                    2'd1:    w_raddr = LA'(w_ub);
                    default: w_raddr = LA'(w_pred ? w_half + r_k : r_k);
                endcase
                w_waddr  = LA'(w_pred ? w_half + r_k : r_k);
                w_lwe    = (r_m == 2'd3);
                w_lwdata = lwt_pkg::sat_wide(w_res);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            line_mem[w_waddr] <= w_lwdata;
        end
        r_lq <= line_mem[w_raddr];
        r_d1 <= w_dest;
        r_d2 <= r_d1;
        r_sc1 <= w_sel;
        r_a  <= n_a;
        r_b  <= n_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lwt_pkg::E_IDLE;
            r_inv   <= 1'b0;
            r_lv    <= '0;
            r_lvl   <= '0;
            r_pass  <= 1'b0;
            r_w     <= '0;
            r_h     <= '0;
            r_line  <= '0;
            r_k     <= '0;
            r_m     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inv   <= n_inv;
            r_lv    <= n_lv;
            r_lvl   <= n_lvl;
            r_pass  <= n_pass;
            r_w     <= n_w;
            r_h     <= n_h;
            r_line  <= n_line;
            r_k     <= n_k;
            r_m     <= n_m;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_inv   = r_inv;
        n_lv    = r_lv;
        n_lvl   = r_lvl;
        n_pass  = r_pass;
        n_w     = r_w;
        n_h     = r_h;
        n_line  = r_line;
        n_k     = r_k;
        n_m     = r_m;
        n_a     = r_a;
        n_b     = r_b;
        o_done  = 1'b0;

        unique case (r_state)
            lwt_pkg::E_IDLE: begin
                if (i_cmd.start) begin
                    n_inv   = i_cmd.inv;
                    n_lv    = i_cmd.lv;
                    n_lvl   = '0;
                    n_pass  = 1'b0;
                    n_line  = '0;
                    n_k     = '0;
                    n_w     = i_cmd.inv ? i_cmd.w >> (i_cmd.lv - LV'(1)) : i_cmd.w;
                    n_h     = i_cmd.inv ? i_cmd.h >> (i_cmd.lv - LV'(1)) : i_cmd.h;
                    n_state = lwt_pkg::E_LOAD;
                end
            end
            lwt_pkg::E_LOAD: begin
                n_k = r_k + DW'(1);
                if (r_k == w_n + DW'(1)) begin
                    n_k     = '0;
                    n_m     = '0;
                    n_state = lwt_pkg::E_LIFT1;
                end
            end
            lwt_pkg::E_LIFT1, lwt_pkg::E_LIFT2: begin
                n_m = r_m + 2'd1;
                if (r_m == 2'd1) begin
                    n_a = r_lq;
                end
                if (r_m == 2'd2) begin
                    n_b = r_lq;
                end
                if (r_m == 2'd3) begin
                    n_k = r_k + DW'(1);
                    if (r_k == w_half - DW'(1)) begin
                        n_k     = '0;
                        n_state = (r_state == lwt_pkg::E_LIFT1) ? lwt_pkg::E_LIFT2
                                                                 : lwt_pkg::E_STORE;
                    end
                end
            end
            lwt_pkg::E_STORE: begin
                n_k = r_k + DW'(1);
                if (r_k == w_n + DW'(1)) begin
                    n_k     = '0;
                    n_line  = r_line + DW'(1);
                    n_state = lwt_pkg::E_LOAD;
                    if (r_line == w_cnt - DW'(1)) begin
                        n_line = '0;
                        if (!r_pass) begin
                            n_pass = 1'b1;
                        end else if (r_lvl == r_lv - LV'(1)) begin
                            n_state = lwt_pkg::E_IDLE;
                            o_done  = 1'b1;
                        end else begin
                            n_pass = 1'b0;
                            n_lvl  = r_lvl + LV'(1);
                            n_w    = r_inv ? r_w << 1 : r_w >> 1;
                            n_h    = r_inv ? r_h << 1 : r_h >> 1;
                        end
                    end
                end
            end
            default: begin
                n_state = lwt_pkg::E_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fmem.we |-> r_state == lwt_pkg::E_STORE)
        else $error("frame written outside store phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lwt_pkg::E_LIFT1 || r_state == lwt_pkg::E_LIFT2) |-> !r_v1 && !r_v2)
        else $error("transfer still in flight during lifting");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == lwt_pkg::E_IDLE)
        else $error("engine did not return to idle");
endmodule
`default_nettype wire

// ----- tb/sv/lifting_wavelet_2d_multilevel_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lifting_wavelet_2d_multilevel: loads, runs and reads through the
// start/busy port, compared against an in-bench 5/3 lifting predictor. Depends on lwt_pkg.
module lifting_wavelet_2d_multilevel_test;

    localparam int MAX_WIDTH  = lwt_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = lwt_pkg::MAX_HEIGHT;
    localparam int MAX_LEVELS = lwt_pkg::MAX_LEVELS;
    localparam int LINE_LEN   = lwt_pkg::LINE_LEN;
    localparam int FRAME_SZ   = MAX_WIDTH * MAX_HEIGHT;

    typedef struct {
        logic [31:0]   value;
        logic [1:0]    status;
        lwt_pkg::t_req kind;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = lwt_pkg::REQ_LOAD;
    logic [8:0]         i_row = '0;
    logic [8:0]         i_col = '0;
    logic signed [31:0] i_sample = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = lwt_pkg::CFG_MODE;
    logic [9:0]         i_cfg_data = '0;
    logic               o_done;
    logic signed [31:0] o_value;
    logic [1:0]         o_status;

    lifting_wavelet_2d_multilevel uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_row(i_row), .i_col(i_col), .i_sample(i_sample),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_value(o_value), .o_status(o_status)
    );

    always #1 i_clk = ~i_clk;

    longint  frame_img [FRAME_SZ];
    bit      frame_set [FRAME_SZ];
    longint  line_buf [LINE_LEN];
    longint  lo_hi [LINE_LEN];
    int      mode_reg = 0, width_reg = 512, height_reg = 512, levels_reg = 1;
    t_answer pending [$];
    int      n_sent = 0, n_checked = 0, n_errors = 0, n_runs = 0, n_bad_runs = 0;
    bit      calm = 1'b0;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scale_q30(longint x, longint c);
        logic [63:0] mag, prod;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        prod = mag * 64'(c);
        prod = (prod + (64'd1 << 29)) >> 30;
        return clip32((x < 0) ? -longint'(prod) : longint'(prod));
    endfunction

    function automatic void lift_fwd(int n);
        int h;
        h = n / 2;
        for (int i = 0; i < h; i++) begin
            lo_hi[i] = line_buf[2*i];
            lo_hi[h+i] = line_buf[2*i+1];
        end
        for (int i = 0; i + 1 < h; i++)
            lo_hi[h+i] = clip32(lo_hi[h+i] - ((lo_hi[i] + lo_hi[i+1]) >>> 1));
        lo_hi[2*h-1] = clip32(lo_hi[2*h-1] - ((lo_hi[h-1] + lo_hi[h-2]) >>> 1));
        lo_hi[0] = clip32(lo_hi[0] + ((lo_hi[h] + lo_hi[h+1]) >>> 2));
        for (int i = 1; i < h; i++)
            lo_hi[i] = clip32(lo_hi[i] + ((lo_hi[h+i] + lo_hi[h+i-1]) >>> 2));
        for (int i = 0; i < h; i++) begin
            line_buf[i] = scale_q30(lo_hi[i], lwt_pkg::ROOT2_Q30);
            line_buf[h+i] = scale_q30(lo_hi[h+i], lwt_pkg::INVROOT2_Q30);
        end
    endfunction

    function automatic void lift_inv(int n);
        int h;
        h = n / 2;
        for (int i = 0; i < h; i++) begin
            lo_hi[i] = scale_q30(line_buf[i], lwt_pkg::INVROOT2_Q30);
            lo_hi[h+i] = scale_q30(line_buf[h+i], lwt_pkg::ROOT2_Q30);
        end
        lo_hi[0] = clip32(lo_hi[0] - ((lo_hi[h] + lo_hi[h+1]) >>> 2));
        for (int i = 1; i < h; i++)
            lo_hi[i] = clip32(lo_hi[i] - ((lo_hi[h+i] + lo_hi[h+i-1]) >>> 2));
        for (int i = 0; i + 1 < h; i++)
            lo_hi[h+i] = clip32(lo_hi[h+i] + ((lo_hi[i] + lo_hi[i+1]) >>> 1));
        lo_hi[2*h-1] = clip32(lo_hi[2*h-1] + ((lo_hi[h-1] + lo_hi[h-2]) >>> 1));
        for (int i = 0; i < h; i++) begin
            line_buf[2*i] = lo_hi[i];
            line_buf[2*i+1] = lo_hi[h+i];
        end
    endfunction

    function automatic void lift_rows(int w, int ht, bit inv);
        for (int y = 0; y < ht; y++) begin
            for (int x = 0; x < w; x++) line_buf[x] = frame_img[y*MAX_WIDTH+x];
            if (inv) lift_inv(w); else lift_fwd(w);
            for (int x = 0; x < w; x++) frame_img[y*MAX_WIDTH+x] = line_buf[x];
        end
    endfunction

    function automatic void lift_cols(int w, int ht, bit inv);
        for (int x = 0; x < w; x++) begin
            for (int y = 0; y < ht; y++) line_buf[y] = frame_img[y*MAX_WIDTH+x];
            if (inv) lift_inv(ht); else lift_fwd(ht);
            for (int y = 0; y < ht; y++) frame_img[y*MAX_WIDTH+x] = line_buf[y];
        end
    endfunction

    function automatic bit size_ok(int w, int ht, int lv);
        if (lv < 1 || lv > MAX_LEVELS || w > MAX_WIDTH || ht > MAX_HEIGHT) return 1'b0;
        if (((w >> lv) << lv) != w || ((ht >> lv) << lv) != ht) return 1'b0;
        return (w >> lv) >= 2 && (ht >> lv) >= 2;
    endfunction

    function automatic logic [1:0] transform_frame();
        int w, ht;
        w = width_reg;
        ht = height_reg;
        if (!size_ok(w, ht, levels_reg)) return lwt_pkg::ST_BAD_SIZE;
        if (mode_reg == 0) begin
            for (int n = 0; n < levels_reg; n++) begin
                lift_rows(w, ht, 1'b0);
                lift_cols(w, ht, 1'b0);
                w /= 2;
                ht /= 2;
            end
        end else begin
            w = w >> (levels_reg - 1);
            ht = ht >> (levels_reg - 1);
            for (int n = 0; n < levels_reg; n++) begin
                lift_cols(w, ht, 1'b1);
                lift_rows(w, ht, 1'b1);
                w *= 2;
                ht *= 2;
            end
        end
        return lwt_pkg::ST_OK;
    endfunction

    function automatic bit in_frame(int r, int c);
        return r < height_reg && r < MAX_HEIGHT && c < width_reg && c < MAX_WIDTH;
    endfunction

    function automatic t_answer frame_answer(lwt_pkg::t_req k, int r, int c,
                                             logic [31:0] smp);
        t_answer a;
        a.value = '0;
        a.status = lwt_pkg::ST_OK;
        a.kind = k;
        case (k)
            lwt_pkg::REQ_LOAD: begin
                if (in_frame(r, c)) begin
                    frame_img[r*MAX_WIDTH+c] = longint'(signed'(smp));
                    frame_set[r*MAX_WIDTH+c] = 1'b1;
                end else begin
                    a.status = lwt_pkg::ST_BAD_INDEX;
                end
            end
            lwt_pkg::REQ_RUN: begin
                a.status = transform_frame();
                n_runs++;
                if (a.status != lwt_pkg::ST_OK) n_bad_runs++;
            end
            lwt_pkg::REQ_READ: begin
                if (in_frame(r, c)) a.value = frame_img[r*MAX_WIDTH+c][31:0];
                else a.status = lwt_pkg::ST_BAD_INDEX;
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_done) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%0d", $time, o_value, o_status);
                n_errors++;
            end else begin
                e = pending.pop_front();
                n_checked++;
                if (o_value !== e.value) begin
                    $display("%0t: %s value expected %h actual %h", $time, e.kind.name(),
                             e.value, o_value);
                    n_errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: %s status expected %0d actual %0d", $time, e.kind.name(),
                             e.status, o_status);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_request(lwt_pkg::t_req k, int r, int c, logic [31:0] smp);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        start = 1'b1;
        i_req_type = k;
        i_row = 9'(r);
        i_col = 9'(c);
        i_sample = smp;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending.push_back(frame_answer(k, r, c, smp));
        n_sent++;
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            i_sample = $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int data);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = 10'(data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            lwt_pkg::CFG_MODE:   mode_reg = data & 1;
            lwt_pkg::CFG_WIDTH:  width_reg = data & 10'h3FF;
            lwt_pkg::CFG_HEIGHT: height_reg = data & 10'h3FF;
            default:             levels_reg = data & 4'hF;
        endcase
    endtask

    task automatic set_frame(int m, int w, int ht, int lv);
        write_reg(lwt_pkg::CFG_MODE, m);
        write_reg(lwt_pkg::CFG_WIDTH, w);
        write_reg(lwt_pkg::CFG_HEIGHT, ht);
        write_reg(lwt_pkg::CFG_LEVELS, lv);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return 32'($urandom_range(0, 8191)) - 32'd4096;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_region();
        for (int r = 0; r < height_reg; r++)
            for (int c = 0; c < width_reg; c++)
                if (!frame_set[r*MAX_WIDTH+c])
                    send_request(lwt_pkg::REQ_LOAD, r, c, pick_sample());
    endtask

    task automatic read_some(int n);
        int r, c;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, height_reg - 1);
            c = $urandom_range(0, width_reg - 1);
            if (frame_set[r*MAX_WIDTH+c]) send_request(lwt_pkg::REQ_READ, r, c, $urandom);
        end
    endtask

    task automatic test_directed();
        logic [31:0] edge_vals [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        set_frame(0, 4, 4, 1);
        for (int i = 0; i < 16; i++)
            send_request(lwt_pkg::REQ_LOAD, i / 4, i % 4,
                         (i < 8) ? edge_vals[i % 4] : pick_sample());
        send_request(lwt_pkg::REQ_LOAD, 4, 0, 32'h1234_5678);
        send_request(lwt_pkg::REQ_NONE, 0, 0, 32'h0);
        send_request(lwt_pkg::REQ_RUN, 0, 0, 32'h0);
        send_request(lwt_pkg::REQ_READ, 0, 0, 32'h0);
        send_request(lwt_pkg::REQ_READ, 3, 3, 32'h0);
        send_request(lwt_pkg::REQ_READ, 0, 511, 32'h0);
        write_reg(lwt_pkg::CFG_MODE, 1);
        send_request(lwt_pkg::REQ_RUN, 0, 0, 32'h0);
        send_request(lwt_pkg::REQ_READ, 1, 2, 32'h0);
    endtask

    task automatic test_bad_sizes();
        int cases [7][3] = '{'{8, 8, 0}, '{8, 8, 15}, '{8, 8, 8}, '{10, 8, 2},
                             '{1000, 8, 1}, '{4, 8, 2}, '{0, 8, 1}};
        foreach (cases[i]) begin
            set_frame($urandom_range(0, 1), cases[i][0], cases[i][1], cases[i][2]);
            send_request(lwt_pkg::REQ_RUN, 0, 0, 32'h0);
        end
    endtask

    task automatic test_full_extent();
        set_frame(0, 512, 512, 8);
        send_request(lwt_pkg::REQ_LOAD, 511, 511, 32'hA5A5_5A5A);
        send_request(lwt_pkg::REQ_LOAD, 256, 255, 32'h0000_0100);
        send_request(lwt_pkg::REQ_READ, 511, 511, 32'h0);
        send_request(lwt_pkg::REQ_READ, 256, 255, 32'h0);
        write_reg(lwt_pkg::CFG_WIDTH, 256);
        write_reg(lwt_pkg::CFG_HEIGHT, 256);
        send_request(lwt_pkg::REQ_LOAD, 300, 7, 32'h1);
        send_request(lwt_pkg::REQ_READ, 7, 300, 32'h1);
    endtask

    task automatic test_random();
        int dims_w [5] = '{4, 8, 8, 16, 32};
        int dims_h [5] = '{4, 4, 8, 8, 16};
        int w, ht, lmax;
        while (n_sent < 850) begin
            calm = ($urandom_range(0, 3) == 0);
            w = dims_w[$urandom_range(0, 4)];
            ht = dims_h[$urandom_range(0, 4)];
            lmax = $clog2((w < ht) ? w : ht) - 1;
            set_frame($urandom_range(0, 1), w, ht, $urandom_range(1, lmax));
            fill_region();
            for (int i = $urandom_range(0, 6); i > 0; i--) begin
                case ($urandom_range(0, 4))
                    0: send_request(lwt_pkg::REQ_LOAD, $urandom_range(ht, 511),
                                    $urandom_range(0, 511), $urandom);
                    1: send_request(lwt_pkg::REQ_READ, $urandom_range(0, 511),
                                    $urandom_range(w, 511), $urandom);
                    2: send_request(lwt_pkg::REQ_NONE, $urandom_range(0, 511),
                                    $urandom_range(0, 511), $urandom);
                    default: send_request(lwt_pkg::REQ_LOAD, $urandom_range(0, ht - 1),
                                          $urandom_range(0, w - 1), pick_sample());
                endcase
            end
            send_request(lwt_pkg::REQ_RUN, 0, 0, $urandom);
            read_some($urandom_range(3, 10));
            if ($urandom_range(0, 1)) begin
                write_reg(lwt_pkg::CFG_MODE, mode_reg ^ 1);
                send_request(lwt_pkg::REQ_RUN, 0, 0, $urandom);
                read_some($urandom_range(2, 6));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_bad_sizes();
        test_full_extent();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests, %0d transform runs (%0d with bad size), %0d results checked",
                 n_sent, n_runs, n_bad_runs, n_checked);
        if (n_errors == 0 && pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d results outstanding", pending.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
